// ===== hdl/rci_pkg.sv =====
// Shared constants, types and saturating fixed-point helpers for the ray/cone intersection core.
// No dependencies; every other file of the core imports this package.
package rci_pkg;

  localparam int FRAC_BITS = 16;
  localparam int XW = 64 + FRAC_BITS;
  localparam int SQ_N = (XW + 1) / 2;
  localparam int QW = 31 + FRAC_BITS;
  localparam int MUL_LAT = 2;
  localparam int SQ_LAT = SQ_N;
  localparam int DIV_LAT = 64;
  localparam int QDEPTH = 4;
  localparam int QPW = $clog2(QDEPTH);
  localparam int ONE_Q = 2 ** FRAC_BITS;

  typedef logic signed [63:0] fx_t;

  localparam fx_t SAT_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam fx_t EPS_Q = 64'((ONE_Q + 9999) / 10000);
  localparam fx_t MIN_T = 64'((ONE_Q + 99) / 100);
  localparam fx_t DIST_MAX = 64'h0000_0000_7fff_ffff;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0] radius;
    logic [30:0] height;
    fx_t tan2;
  } cfg_t;

  typedef struct packed {
    logic miss;
    fx_t a;
    fx_t b;
    fx_t delta;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
  } quad_t;

  function automatic fx_t sadd(fx_t x, fx_t y);
    logic signed [64:0] s;
    s = 65'(x) + 65'(y);
    if (s > 65'(SAT_MAX)) return SAT_MAX;
    else if (s < -65'(SAT_MAX)) return -SAT_MAX;
    return s[63:0];
  endfunction

  function automatic fx_t ssub(fx_t x, fx_t y);
    return sadd(x, -y);
  endfunction

  function automatic logic [63:0] mag(fx_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage

// ===== hdl/ray_cone_intersect_core.sv =====
// Ray against upright finite cone test, one ray beat per clock while busy is low; results
// cannot be stalled. From the start beat to done a ray passes 10 front stages, the queue,
// then a 40-stage square root, 64-stage dividers and the height test in the back pipeline.
// After a write to the radius or height register, busy stays high while the squared slope
// is recomputed by a bit-serial divider and a multiplier. Reset is synchronous and restores
// the register defaults (unit radius and height, base at the origin).
module ray_cone_intersect_core import rci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  output logic               done,
  output logic               hit,
  output logic [30:0]        distance
);

  cfg_t cfg;
  logic fv, qv;
  quad_t fq, qq;

  rci_cfg u_cfg (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .cfg(cfg), .busy(busy)
  );

  rci_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .cfg(cfg), .out_valid(fv), .out(fq)
  );

  rci_fifo u_fifo (
    .clk(clk), .rst(rst), .push(fv), .push_data(fq), .pop_valid(qv), .pop_data(qq)
  );

  rci_back u_back (
    .clk(clk), .rst(rst), .in_valid(qv), .in(qq), .cfg(cfg),
    .done(done), .hit(hit), .distance(distance)
  );

endmodule

// ===== hdl/rci_mul.sv =====
// Two-stage saturating signed fixed-point multiplier built from four 32x32 partial products.
// Depends on rci_pkg.
module rci_mul import rci_pkg::*; (
  input  logic clk,
  input  fx_t  a,
  input  fx_t  b,
  output fx_t  p
);

  logic [63:0] ma, mb;
  logic [63:0] p00, p01, p10, p11;
  logic neg;
  logic [127:0] prod, sh;
  fx_t m;

  assign ma = mag(a);
  assign mb = mag(b);

  always_ff @(posedge clk) begin
    p00 <= {32'b0, ma[31:0]} * {32'b0, mb[31:0]};
    p01 <= {32'b0, ma[31:0]} * {32'b0, mb[63:32]};
    p10 <= {32'b0, ma[63:32]} * {32'b0, mb[31:0]};
    p11 <= {32'b0, ma[63:32]} * {32'b0, mb[63:32]};
    neg <= a[63] ^ b[63];
  end

  always_comb begin
    prod = {p11, 64'b0} + {32'b0, p01, 32'b0} + {32'b0, p10, 32'b0} + {64'b0, p00};
    sh = prod >> FRAC_BITS;
    m = (|sh[127:63]) ? SAT_MAX : {1'b0, sh[62:0]};
  end

  always_ff @(posedge clk) begin
    p <= neg ? -m : m;
  end

endmodule

// ===== hdl/rci_cfg.sv =====
// Configuration registers and the sequencer that derives the squared cone slope.
// Depends on rci_pkg and rci_mul.
module rci_cfg import rci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg,
  output logic        busy
);

  localparam int CW = $clog2(QW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_MUL  = 4'b1000
  } state_t;

  state_t state;
  logic [QW-1:0] divq;
  logic [30:0] rem, rem_next;
  logic [31:0] sh;
  logic ge;
  logic [CW-1:0] cnt;
  fx_t sq;

  rci_mul u_mul (.clk(clk), .a(64'(divq)), .b(64'(divq)), .p(sq));

  always_comb begin
    sh = {rem, divq[QW-1]};
    ge = sh >= {1'b0, cfg.height};
    rem_next = ge ? 31'(sh - {1'b0, cfg.height}) : sh[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cx <= '0;
      cfg.cy <= '0;
      cfg.cz <= '0;
      cfg.radius <= 31'(ONE_Q);
      cfg.height <= 31'(ONE_Q);
      cfg.tan2 <= 64'(ONE_Q);
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_CENTER_X: cfg.cx <= wr_data;
          REG_CENTER_Y: cfg.cy <= wr_data;
          REG_CENTER_Z: cfg.cz <= wr_data;
          REG_RADIUS:   cfg.radius <= wr_data[30:0];
          REG_HEIGHT:   cfg.height <= wr_data[30:0];
          default: ;
        endcase
      end
      if (wr_en && (wr_index == REG_RADIUS || wr_index == REG_HEIGHT)) begin
        state <= ST_LOAD;
      end else begin
        unique case (state)
          ST_IDLE: ;
          ST_LOAD: begin
            divq <= {cfg.radius, {FRAC_BITS{1'b0}}};
            rem <= '0;
            cnt <= '0;
            state <= ST_DIV;
          end
          ST_DIV: begin
            rem <= rem_next;
            divq <= {divq[QW-2:0], ge};
            if (cnt == CW'(QW - 1)) begin
              cnt <= '0;
              state <= ST_MUL;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          ST_MUL: begin
            if (cnt == CW'(MUL_LAT)) begin
              cfg.tan2 <= sq;
              cnt <= '0;
              state <= ST_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  assign busy = state != ST_IDLE;

endmodule

// ===== hdl/rci_front.sv =====
// Front pipeline: forms the quadratic coefficients and discriminant and classifies misses.
// Depends on rci_pkg and rci_mul.
module rci_front import rci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  cfg_t               cfg,
  output logic               out_valid,
  output quad_t              out
);

  typedef struct packed {
    logic hz;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
  } side_t;

  logic [9:0] vld;
  side_t sd [9];
  fx_t r_dx, r_dy, r_dz, r_ddx, r_ddz, r_yd;
  fx_t m_dxdx, m_dzdz, m_dydy, m_ddxdx, m_ddzdz, m_ydy, m_ddxddx, m_ddzddz, m_yy;
  fx_t sa, sb, sc, sa2, sb2, sc2, t_a, t_b, t_c;
  fx_t a5, b5, c5, a6, b6, a7, b7, a8, b8, m_ac, m_bb, ac2, bb8, ac4, delta;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[8:0], in_valid};
  end

  always_ff @(posedge clk) begin
    r_dx <= 64'(dir_x);
    r_dy <= 64'(dir_y);
    r_dz <= 64'(dir_z);
    r_ddx <= 64'(origin_x) - 64'(signed'(cfg.cx));
    r_ddz <= 64'(origin_z) - 64'(signed'(cfg.cz));
    r_yd <= fx_t'({33'b0, cfg.height}) - 64'(origin_y) + 64'(signed'(cfg.cy));
    sd[0] <= '{hz: cfg.height == '0, oy: origin_y, dy: dir_y};
    for (int i = 1; i < 9; i++) sd[i] <= sd[i-1];
  end

  rci_mul u_m0 (.clk(clk), .a(r_dx),  .b(r_dx),  .p(m_dxdx));
  rci_mul u_m1 (.clk(clk), .a(r_dz),  .b(r_dz),  .p(m_dzdz));
  rci_mul u_m2 (.clk(clk), .a(r_dy),  .b(r_dy),  .p(m_dydy));
  rci_mul u_m3 (.clk(clk), .a(r_ddx), .b(r_dx),  .p(m_ddxdx));
  rci_mul u_m4 (.clk(clk), .a(r_ddz), .b(r_dz),  .p(m_ddzdz));
  rci_mul u_m5 (.clk(clk), .a(r_yd),  .b(r_dy),  .p(m_ydy));
  rci_mul u_m6 (.clk(clk), .a(r_ddx), .b(r_ddx), .p(m_ddxddx));
  rci_mul u_m7 (.clk(clk), .a(r_ddz), .b(r_ddz), .p(m_ddzddz));
  rci_mul u_m8 (.clk(clk), .a(r_yd),  .b(r_yd),  .p(m_yy));

  rci_mul u_t0 (.clk(clk), .a(cfg.tan2), .b(m_dydy), .p(t_a));
  rci_mul u_t1 (.clk(clk), .a(cfg.tan2), .b(m_ydy),  .p(t_b));
  rci_mul u_t2 (.clk(clk), .a(cfg.tan2), .b(m_yy),   .p(t_c));

  rci_mul u_ac (.clk(clk), .a(a5), .b(c5), .p(m_ac));
  rci_mul u_bb (.clk(clk), .a(b5), .b(b5), .p(m_bb));

  always_ff @(posedge clk) begin
    sa <= sadd(m_dxdx, m_dzdz);
    sb <= sadd(m_ddxdx, m_ddzdz);
    sc <= sadd(m_ddxddx, m_ddzddz);
    sa2 <= sa;
    sb2 <= sb;
    sc2 <= sc;
    a5 <= ssub(sa2, t_a);
    b5 <= sadd(sadd(sb2, t_b), sadd(sb2, t_b));
    c5 <= ssub(sc2, t_c);
    a6 <= a5;
    b6 <= b5;
    a7 <= a6;
    b7 <= b6;
    a8 <= a7;
    b8 <= b7;
    ac2 <= sadd(m_ac, m_ac);
    bb8 <= m_bb;
    out.a <= a8;
    out.b <= b8;
    out.delta <= delta;
    out.miss <= sd[8].hz || (delta < EPS_Q) || (a8 == '0);
    out.oy <= sd[8].oy;
    out.dy <= sd[8].dy;
  end

  always_comb begin
    ac4 = sadd(ac2, ac2);
    delta = ssub(bb8, ac4);
  end

  assign out_valid = vld[9];

endmodule

// ===== hdl/rci_fifo.sv =====
// Short queue between the front and back pipelines; the back side drains one entry per cycle.
// Depends on rci_pkg.
module rci_fifo import rci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  quad_t push_data,
  output logic  pop_valid,
  output quad_t pop_data
);

  quad_t mem [QDEPTH];
  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic [QPW:0] count;

  assign pop_valid = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop_valid) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPW+1)'(push) - (QPW+1)'(pop_valid);
    end
  end

endmodule

// ===== hdl/rci_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on rci_pkg.
module rci_sqrt import rci_pkg::*; (
  input  logic            clk,
  input  logic [XW-1:0]   x,
  output logic [SQ_N-1:0] root
);

  localparam int RW = SQ_N + 3;
  localparam int PW = 2 * SQ_N;

  logic [PW-1:0] xs [SQ_N];
  logic [RW-1:0] rem [SQ_N];
  logic [SQ_N-1:0] rt [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_stage
    logic [PW-1:0] x_in;
    logic [RW-1:0] r_in, rsh, trial;
    logic [SQ_N-1:0] t_in;
    logic ge;
    if (i == 0) begin : g_first
      assign x_in = PW'(x);
      assign r_in = '0;
      assign t_in = '0;
    end else begin : g_next
      assign x_in = xs[i-1];
      assign r_in = rem[i-1];
      assign t_in = rt[i-1];
    end
    assign rsh = {r_in[RW-3:0], x_in[PW-1 -: 2]};
    assign trial = RW'({t_in, 2'b01});
    assign ge = rsh >= trial;
    always_ff @(posedge clk) begin
      xs[i] <= {x_in[PW-3:0], 2'b00};
      rem[i] <= ge ? rsh - trial : rsh;
      rt[i] <= {t_in[SQ_N-2:0], ge};
    end
  end

  assign root = rt[SQ_N-1];

endmodule

// ===== hdl/rci_div.sv =====
// Pipelined restoring divider giving a 63-bit quotient that saturates to all ones.
// Depends on rci_pkg.
module rci_div import rci_pkg::*; (
  input  logic          clk,
  input  logic [XW-1:0] x,
  input  logic [63:0]   den,
  output logic [62:0]   q
);

  localparam int NS = DIV_LAT - 1;

  logic sat0;
  logic [63:0] rr0, dn0;
  logic [62:0] xl0;
  logic sat [NS];
  logic [63:0] rr [NS];
  logic [63:0] dn [NS];
  logic [62:0] xl [NS];
  logic [62:0] qq [NS];

  always_ff @(posedge clk) begin
    sat0 <= 64'(x[XW-1:63]) >= den;
    rr0 <= 64'(x[XW-1:63]);
    xl0 <= x[62:0];
    dn0 <= den;
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic s_in, ge;
    logic [63:0] r_in, d_in;
    logic [62:0] x_in, q_in;
    logic [64:0] sh;
    if (i == 0) begin : g_first
      assign s_in = sat0;
      assign r_in = rr0;
      assign d_in = dn0;
      assign x_in = xl0;
      assign q_in = '0;
    end else begin : g_next
      assign s_in = sat[i-1];
      assign r_in = rr[i-1];
      assign d_in = dn[i-1];
      assign x_in = xl[i-1];
      assign q_in = qq[i-1];
    end
    assign sh = {r_in, x_in[62]};
    assign ge = sh >= {1'b0, d_in};
    always_ff @(posedge clk) begin
      sat[i] <= s_in;
      rr[i] <= ge ? 64'(sh - {1'b0, d_in}) : sh[63:0];
      dn[i] <= d_in;
      xl[i] <= {x_in[61:0], 1'b0};
      qq[i] <= {q_in[61:0], ge};
    end
  end

  assign q = sat[NS-1] ? '1 : qq[NS-1];

endmodule

// ===== hdl/rci_back.sv =====
// Back pipeline: square root, both roots, height test and selection of the nearest hit.
// Depends on rci_pkg, rci_sqrt, rci_div and rci_mul.
module rci_back import rci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  quad_t       in,
  input  cfg_t        cfg,
  output logic        done,
  output logic        hit,
  output logic [30:0] distance
);

  localparam int P1 = SQ_LAT + 1;
  localparam int P2 = P1 + DIV_LAT;
  localparam int P4 = P2 + 2;
  localparam int P7 = P4 + MUL_LAT + 1;
  localparam int P8 = P7 + 1;

  typedef struct packed {
    logic miss;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
  } side_t;

  logic [P8:0] vld;
  side_t sd [P7+1];
  fx_t ad [SQ_LAT+1];
  fx_t bd [SQ_LAT+1];
  logic [1:0] ngd [DIV_LAT+1];
  logic [63:0] delta0;
  logic [SQ_N-1:0] s;
  fx_t n1, n2, t1, t2, m_lo, m_hi, y_lo, y_hi, top, found;
  logic [XW-1:0] x1, x2;
  logic [63:0] den, ma;
  logic [62:0] q1, q2;
  fx_t tl [4];
  fx_t th [4];
  logic lo_ok, hi_ok;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[P8-1:0], in_valid};
  end

  always_ff @(posedge clk) begin
    sd[0] <= '{miss: in.miss, oy: in.oy, dy: in.dy};
    for (int i = 1; i <= P7; i++) sd[i] <= sd[i-1];
    ad[0] <= in.a;
    bd[0] <= in.b;
    for (int i = 1; i <= SQ_LAT; i++) begin
      ad[i] <= ad[i-1];
      bd[i] <= bd[i-1];
    end
    delta0 <= in.delta;
  end

  rci_sqrt u_sqrt (.clk(clk), .x({delta0, {FRAC_BITS{1'b0}}}), .root(s));

  always_comb begin
    n1 = sadd(-bd[SQ_LAT], -64'(s));
    n2 = sadd(-bd[SQ_LAT], 64'(s));
    ma = mag(ad[SQ_LAT]);
  end

  always_ff @(posedge clk) begin
    x1 <= {mag(n1), {FRAC_BITS{1'b0}}};
    x2 <= {mag(n2), {FRAC_BITS{1'b0}}};
    den <= {ma[62:0], 1'b0};
    ngd[0] <= {n2[63] ^ ad[SQ_LAT][63], n1[63] ^ ad[SQ_LAT][63]};
    for (int i = 1; i <= DIV_LAT; i++) ngd[i] <= ngd[i-1];
  end

  rci_div u_div1 (.clk(clk), .x(x1), .den(den), .q(q1));
  rci_div u_div2 (.clk(clk), .x(x2), .den(den), .q(q2));

  always_ff @(posedge clk) begin
    t1 <= ngd[DIV_LAT][0] ? -fx_t'({1'b0, q1}) : fx_t'({1'b0, q1});
    t2 <= ngd[DIV_LAT][1] ? -fx_t'({1'b0, q2}) : fx_t'({1'b0, q2});
    tl[0] <= (t1 < t2) ? t1 : t2;
    th[0] <= (t1 < t2) ? t2 : t1;
    for (int i = 1; i < 4; i++) begin
      tl[i] <= tl[i-1];
      th[i] <= th[i-1];
    end
  end

  rci_mul u_mlo (.clk(clk), .a(64'(sd[P4].dy)), .b(tl[0]), .p(m_lo));
  rci_mul u_mhi (.clk(clk), .a(64'(sd[P4].dy)), .b(th[0]), .p(m_hi));

  always_ff @(posedge clk) begin
    y_lo <= sadd(64'(sd[P7-1].oy), m_lo);
    y_hi <= sadd(64'(sd[P7-1].oy), m_hi);
  end

  always_comb begin
    top = 64'(signed'(cfg.cy)) + fx_t'({33'b0, cfg.height});
    lo_ok = (tl[3] >= MIN_T) && (y_lo >= 64'(signed'(cfg.cy))) && (y_lo <= top);
    hi_ok = (th[3] >= MIN_T) && (y_hi >= 64'(signed'(cfg.cy))) && (y_hi <= top);
    found = lo_ok ? tl[3] : th[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[P7];
    end
    hit <= !sd[P7].miss && (lo_ok || hi_ok);
    if (sd[P7].miss || !(lo_ok || hi_ok)) distance <= '0;
    else if (found > DIST_MAX) distance <= '1;
    else distance <= found[30:0];
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ray_cone_intersect_core: predicts hit and distance for each ray beat.
// It depends on rci_pkg for register indexes and the fixed-point type, and on the core alone.
module testbench;
  import rci_pkg::*;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic hit;
    logic [30:0] distance;
  } hit_t;

  class cone_scoreboard;
    longint cx, cy, cz, radius, height;
    hit_t pending[$];
    int errors;

    function new();
      cx = 0; cy = 0; cz = 0; radius = 65536; height = 65536; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_CENTER_X: cx = longint'(signed'(v));
        REG_CENTER_Y: cy = longint'(signed'(v));
        REG_CENTER_Z: cz = longint'(signed'(v));
        REG_RADIUS: radius = longint'(v[30:0]);
        REG_HEIGHT: height = longint'(v[30:0]);
        default: ;
      endcase
    endfunction

    function logic [63:0] absval(fx_t v);
      return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function fx_t signed_sat(logic [63:0] m, bit neg);
      fx_t v;
      v = (m > 64'(SAT_MAX)) ? SAT_MAX : fx_t'(m);
      return neg ? -v : v;
    endfunction

    function fx_t add_sat(fx_t a, fx_t b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(SAT_MAX)) return SAT_MAX;
      if (s < -65'(SAT_MAX)) return -SAT_MAX;
      return s[63:0];
    endfunction

    function fx_t mul_fx(fx_t a, fx_t b);
      logic [127:0] p;
      p = (128'(absval(a)) * 128'(absval(b))) >> FRAC_BITS;
      return signed_sat(p[127:64] != 0 ? 64'(SAT_MAX) : p[63:0], a[63] != b[63]);
    endfunction

    function logic [63:0] sqrt_fx(fx_t d);
      logic [127:0] x;
      logic [63:0] r, c;
      x = 128'(d) << FRAC_BITS;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        c = r | (64'd1 << i);
        if (128'(c) * 128'(c) <= x) r = c;
      end
      return r;
    endfunction

    function fx_t quot_fx(fx_t n, fx_t a);
      logic [127:0] x, qq;
      x = 128'(absval(n)) << FRAC_BITS;
      qq = x / (128'(absval(a)) * 2);
      if (qq > 128'(SAT_MAX)) qq = 128'(SAT_MAX);
      return signed_sat(qq[63:0], n[63] != a[63]);
    endfunction

    function bit within_cone(fx_t oy, fx_t dy, fx_t t);
      fx_t y;
      y = add_sat(oy, mul_fx(dy, t));
      return y >= cy && y <= cy + height;
    endfunction

    function void note_ray(ray_t r);
      fx_t ddx, ddz, yd, q, tan2, a, b, c, ac4, delta, s, t1, t2, tlo, thi, found;
      hit_t e;
      e.hit = 0;
      e.distance = 0;
      found = -1;
      ddx = fx_t'(r.ox) - cx;
      ddz = fx_t'(r.oz) - cz;
      yd = height - fx_t'(r.oy) + cy;
      q = (height == 0) ? 0 : (radius << FRAC_BITS) / height;
      tan2 = mul_fx(q, q);
      a = add_sat(add_sat(mul_fx(r.dx, r.dx), mul_fx(r.dz, r.dz)),
                  -mul_fx(tan2, mul_fx(r.dy, r.dy)));
      b = add_sat(add_sat(mul_fx(ddx, r.dx), mul_fx(ddz, r.dz)),
                  mul_fx(tan2, mul_fx(yd, r.dy)));
      b = add_sat(b, b);
      c = add_sat(add_sat(mul_fx(ddx, ddx), mul_fx(ddz, ddz)),
                  -mul_fx(tan2, mul_fx(yd, yd)));
      ac4 = mul_fx(a, c);
      ac4 = add_sat(ac4, ac4);
      ac4 = add_sat(ac4, ac4);
      delta = add_sat(mul_fx(b, b), -ac4);
      if (height != 0 && !(delta < EPS_Q || a == 0)) begin
        s = fx_t'(sqrt_fx(delta));
        t1 = quot_fx(add_sat(-b, -s), a);
        t2 = quot_fx(add_sat(-b, s), a);
        tlo = t1 < t2 ? t1 : t2;
        thi = t1 < t2 ? t2 : t1;
        if (tlo >= MIN_T && within_cone(r.oy, r.dy, tlo)) found = tlo;
        else if (thi >= MIN_T && within_cone(r.oy, r.dy, thi)) found = thi;
        if (found >= 0) begin
          e.hit = 1;
          e.distance = found > DIST_MAX ? 31'h7fff_ffff : found[30:0];
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic h, logic [30:0] d);
      hit_t e;
      if (pending.size() == 0) begin
        $error("result with no ray outstanding: hit %0d distance %0d", h, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, h);
        errors++;
      end
      if (d !== e.distance) begin
        $error("distance: expected %0d, actual %0d", e.distance, d);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic wr_en = 0;
  logic [2:0] wr_index = 0;
  logic [31:0] wr_data = 0;
  logic done, hit;
  logic [30:0] distance;

  cone_scoreboard sb = new();

  always #5 clk = ~clk;

  ray_cone_intersect_core DUT (.*);

  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_ray('{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z});
    if (!rst && done) sb.check_result(hit, distance);
  end

  task automatic send_ray(ray_t r);
    start <= 1;
    origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
    dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    wr_en <= 1; wr_index <= idx; wr_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    wr_en <= 0;
  endtask

  task automatic load_cone(longint x, longint y, longint z, longint r, longint h);
    drain();
    write_reg(REG_CENTER_X, 32'(x));
    write_reg(REG_CENTER_Y, 32'(y));
    write_reg(REG_CENTER_Z, 32'(z));
    write_reg(REG_RADIUS, 32'(r));
    write_reg(REG_HEIGHT, 32'(h));
  endtask

  function automatic longint spread(longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  function automatic ray_t aimed_ray();
    longint s, tx, ty, tz, ox, oy, oz;
    ray_t r;
    s = sb.height > sb.radius ? sb.height : sb.radius;
    if (s > 64'h0100_0000) s = 64'h0100_0000;
    ty = sb.cy + spread(sb.height / 2) + sb.height / 2;
    tx = sb.cx + spread(sb.radius / 2);
    tz = sb.cz + spread(sb.radius / 2);
    ox = tx + spread(4 * s);
    oy = ty + spread(4 * s);
    oz = tz + spread(4 * s);
    r.ox = 32'(ox); r.oy = 32'(oy); r.oz = 32'(oz);
    r.dx = 32'(tx - ox); r.dy = 32'(ty - oy); r.dz = 32'(tz - oz);
    if ($urandom_range(0, 3) == 0) begin
      r.dx = r.dx >>> 2; r.dy = r.dy >>> 2; r.dz = r.dz >>> 2;
    end
    return r;
  endfunction

  task automatic random_rays(int n);
    ray_t r;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        if ($urandom_range(0, 9) < 7) r = aimed_ray();
        else r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        send_ray(r);
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_ray('{0, 0, 0, 0, 0, 0});
    send_ray('{-4 * ONE, ONE / 2, 0, ONE, 0, 0});
    send_ray('{4 * ONE, ONE / 2, 0, -ONE, 0, 0});
    send_ray('{0, 4 * ONE, 0, 0, -ONE, 0});
    send_ray('{0, -4 * ONE, 0, 0, ONE, 0});
    send_ray('{0, ONE / 2, 0, ONE, 0, 0});
    send_ray('{ONE / 4, ONE / 2, 0, -ONE, 0, 0});
    send_ray('{-4 * ONE, ONE / 2, 0, -ONE, 0, 0});
    send_ray('{-4 * ONE, 0, 0, ONE, ONE, 0});
    send_ray('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
    send_ray('{MINV, MINV, MINV, MINV, MINV, MINV});
    send_ray('{MINV, MAXV, MINV, MAXV, MINV, MAXV});
    send_ray('{-ONE, ONE / 2, 0, 1, 0, 0});
    send_ray('{-4 * ONE, 0, 0, ONE, ONE, ONE});
    send_ray('{-1, -1, -1, -1, -1, -1});
    random_rays(200);
    load_cone(3 * ONE / 2, -2 * ONE, 3 * ONE, 2 * ONE, 3 * ONE);
    random_rays(200);
    load_cone(0, 0, 0, 1, 1);
    random_rays(120);
    load_cone(-5 * ONE, 7 * ONE, -ONE, 32'h7fff_ffff, 32'h7fff_ffff);
    random_rays(120);
    load_cone(MAXV, MINV, MINV, ONE / 8, 32'h7fff_ffff);
    random_rays(100);
    load_cone(MINV, MAXV, MAXV, 32'h7fff_ffff, ONE / 16);
    random_rays(100);
    load_cone(ONE, ONE, -ONE, ONE / 2, 2 * ONE);
    random_rays(200);
    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
